@@ hdl/sbms_pkg.sv @@
// sbms_pkg: shared types, codes and defaults for the shared-buffer multi-stack.
// No dependencies; imported by every module of the block except sbms_ram.
package sbms_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int MAX_STACKS_DEF = 8;

  localparam int DATA_W      = 32;
  localparam int SID_FIELD_W = 3;
  localparam int CFG_W       = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CFG_W-1:0] STACKS_IN_USE_RST = CFG_W'(8);

  // word index of the configuration register (paddr bit 2)
  localparam logic REG_STACKS_IN_USE = 1'b0;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // transaction accepted: latch request, launch memory reads
    logic commit;  // update stacks and load the result register
  } ctl_cmd_t;

endpackage

@@ hdl/sbms_ram.sv @@
// sbms_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module sbms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/sbms_ctrl.sv @@
// sbms_ctrl: request sequencer for the multi-stack (accept, execute, result hand-off).
// Depends on sbms_pkg.
module sbms_ctrl
  import sbms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid && (state_r == S_IDLE);
  // result register must be free (or draining) before the state update
  assign cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter execute");

  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("commit did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.commit)
    else $error("pending result overwritten");

endmodule

@@ hdl/sbms_dpath.sv @@
// sbms_dpath: pointers, slot/link memories and result register of the multi-stack.
// Depends on sbms_pkg and sbms_ram.
module sbms_dpath
  import sbms_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int MAX_STACKS = MAX_STACKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_cmd_t                 cmd,
  input  logic [CFG_W-1:0]         stacks_in_use,
  input  logic                     in_cmd,
  input  logic [SID_FIELD_W-1:0]   in_stack_id,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_pop_value,
  output logic                     out_store_full,
  output logic                     out_stack_empty
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PTR_W = IDX_W + 1;
  localparam logic [PTR_W-1:0] END_PTR = PTR_W'(CAPACITY);
  localparam int SID_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CMP_W = ((SID_W > SID_FIELD_W) ? SID_W : SID_FIELD_W) + 1;

  // pointer state
  logic [PTR_W-1:0] tops_r [MAX_STACKS];
  logic [PTR_W-1:0] free_head_r, free_head_nxt;
  logic [PTR_W-1:0] fill_r, fill_nxt;     // slots [0, fill) have a written link

  // latched request
  cmd_t              cmd_r;
  logic [SID_W-1:0]  sid_r;
  logic              sid_ok_r;
  logic [DATA_W-1:0] val_r;
  logic [PTR_W-1:0]  slot_r;

  // accept-cycle decode
  logic [CMP_W-1:0]  sid_wide;
  logic [SID_W-1:0]  sid_idx;
  logic              sid_in_range;
  logic              sid_ok;
  logic [PTR_W-1:0]  top_sel;
  logic [PTR_W-1:0]  rd_ptr;

  // execute-cycle logic
  logic [DATA_W-1:0] val_rdata;
  logic [PTR_W-1:0]  link_rdata;
  logic [PTR_W-1:0]  link_rd;
  logic [PTR_W-1:0]  top_cur;
  logic              slot_end;
  logic              push_ok, pop_ok;
  logic              val_we, link_we;
  logic [PTR_W-1:0]  link_wdata;
  status_t           status_nxt;
  logic              empty_nxt;

  logic [1:0]        status_r;
  logic [DATA_W-1:0] pop_value_r;
  logic              store_full_r;
  logic              stack_empty_r;

  assign sid_wide     = CMP_W'(in_stack_id);
  assign sid_idx      = sid_wide[SID_W-1:0];
  assign sid_in_range = (sid_wide < CMP_W'(MAX_STACKS));
  assign sid_ok       = sid_in_range && ({1'b0, in_stack_id} < stacks_in_use);
  assign top_sel      = sid_in_range ? tops_r[sid_idx] : END_PTR;
  assign rd_ptr       = (cmd_t'(in_cmd) == CMD_PUSH) ? free_head_r : top_sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= cmd_t'(in_cmd);
      sid_r    <= sid_idx;
      sid_ok_r <= sid_ok;
      val_r    <= DATA_W'(in_push_value);
      slot_r   <= rd_ptr;
    end
  end

  sbms_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_r[IDX_W-1:0]),
    .wdata (val_r),
    .re    (cmd.load),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (val_rdata)
  );

  sbms_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (slot_r[IDX_W-1:0]),
    .wdata (link_wdata),
    .re    (cmd.load),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (link_rdata)
  );

  // untouched slots read as their reset link (next slot, end marker after the last)
  assign link_rd  = (slot_r >= fill_r) ? (slot_r + 1'b1) : link_rdata;
  assign top_cur  = tops_r[sid_r];
  assign slot_end = (slot_r == END_PTR);
  assign push_ok  = sid_ok_r && (cmd_r == CMD_PUSH) && !slot_end;
  assign pop_ok   = sid_ok_r && (cmd_r == CMD_POP) && !slot_end;
  assign val_we   = cmd.commit && push_ok;
  assign link_we  = cmd.commit && (push_ok || pop_ok);
  assign link_wdata = push_ok ? top_cur : free_head_r;

  always_comb begin
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    status_nxt    = ST_OK;
    empty_nxt     = 1'b0;
    if (!sid_ok_r) begin
      status_nxt = ST_BAD;
    end else if (cmd_r == CMD_PUSH) begin
      if (slot_end) begin
        status_nxt = ST_FULL;
        empty_nxt  = (top_cur == END_PTR);
      end else begin
        free_head_nxt = link_rd;
        if (slot_r == fill_r) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
    end else begin
      if (slot_end) begin
        status_nxt = ST_EMPTY;
        empty_nxt  = 1'b1;
      end else begin
        free_head_nxt = slot_r;
        empty_nxt     = (link_rd == END_PTR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fill_r      <= '0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        tops_r[i] <= END_PTR;
      end
    end else if (cmd.commit) begin
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      if (push_ok) begin
        tops_r[sid_r] <= slot_r;
      end else if (pop_ok) begin
        tops_r[sid_r] <= link_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r      <= status_nxt;
      pop_value_r   <= pop_ok ? val_rdata : '0;
      store_full_r  <= (free_head_nxt == END_PTR);
      stack_empty_r <= empty_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_pop_value   = $signed(pop_value_r);
  assign out_store_full  = store_full_r;
  assign out_stack_empty = stack_empty_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= END_PTR)
    else $error("fill count beyond capacity");

  a_free_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= END_PTR)
    else $error("free-list head out of range");

  a_push_slot_known: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && push_ok) |-> (slot_r <= fill_r))
    else $error("push took a slot beyond the untouched region");

endmodule

@@ hdl/shared_buffer_multi_stack.sv @@
// shared_buffer_multi_stack: top level of the multi-stack with shared slot store.
// Depends on sbms_pkg, sbms_ctrl, sbms_dpath (and sbms_ram through it).
//
// Usage
// - Input channel (in_valid/in_ready): one transaction is one request, in_cmd
//   (push or pop), in_stack_id and in_push_value (ignored on pop).
// - Output channel (out_valid/out_ready): one result per request: out_status
//   (ok, store full, stack empty, bad stack number), out_pop_value (zero unless
//   a pop succeeded), out_store_full and out_stack_empty after the request.
// - Configuration: APB-style port; register stacks_in_use at byte address 0
//   (4 bits, reset 8). Stack numbers at or above it, or at or above MAX_STACKS,
//   are rejected. Write only while idle.
// - Timing: the accept cycle launches the link and value memory reads at the chosen
//   slot; the execute state then uses the read data to update pointers and write
//   back. A new request is accepted only after the previous one has been updated,
//   as set by that dependent read-then-write-back sequence through the registered-read
//   memories. out_valid rises at the update edge, which ends the execute state; the
//   result is taken at an edge where out_ready is high.
// - Stall: a finished result waits in the output register; a new request is
//   accepted meanwhile, but its update holds until that result is taken.
// - Reset: rst_n synchronous, active low. All stacks empty, free list runs
//   slot 0 upward; no clearing pass (untouched slots are tracked by a fill
//   count), so requests are taken from the first cycle after reset.
module shared_buffer_multi_stack
  import sbms_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int MAX_STACKS = MAX_STACKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [SID_FIELD_W-1:0]   in_stack_id,
  input  logic signed [DATA_W-1:0] in_push_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_pop_value,
  output logic                     out_store_full,
  output logic                     out_stack_empty,
  // configuration port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [PADDR_W-1:0]       cfg_paddr,
  input  logic [PDATA_W-1:0]       cfg_pwdata,
  output logic [PDATA_W-1:0]       cfg_prdata,
  output logic                     cfg_pready
);

  ctl_cmd_t         cmd;
  logic [CFG_W-1:0] stacks_in_use_r;
  logic             cfg_wr;

  // register decode on the word address; transaction completes in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stacks_in_use_r <= STACKS_IN_USE_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_STACKS_IN_USE)) begin
      stacks_in_use_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_STACKS_IN_USE) ?
                      PDATA_W'(stacks_in_use_r) : '0;

  sbms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sbms_dpath #(
    .CAPACITY   (CAPACITY),
    .MAX_STACKS (MAX_STACKS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stacks_in_use   (stacks_in_use_r),
    .in_cmd          (in_cmd),
    .in_stack_id     (in_stack_id),
    .in_push_value   (in_push_value),
    .out_status      (out_status),
    .out_pop_value   (out_pop_value),
    .out_store_full  (out_store_full),
    .out_stack_empty (out_stack_empty)
  );

endmodule
